[hw/rtl/agl_pkg.sv]
// shared types, constants and saturating arithmetic helpers for the gradient core
package agl_pkg;

  localparam int DW = 48;
  localparam int VW = 47;
  localparam int CW = 16;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] CFG_MA1 = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MA2 = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ARCH1 = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ARCH2 = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_GARCH1 = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_GARCH2 = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_WARMUP = 3'd6;

  localparam logic [CW-1:0] WARMUP_RST = 16'd2;
  localparam logic [CW-1:0] CNT_MAX = 16'hffff;

  localparam logic signed [DW-1:0] ONE_Q = 48'sd16777216;
  localparam logic signed [DW-1:0] MINUS_ONE_Q = -48'sd16777216;
  localparam logic signed [DW:0] MAX48_W = 49'sd140737488355327;
  localparam logic signed [DW:0] MIN48_W = -49'sd140737488355328;
  localparam logic [DW-1:0] LIM_POS = 48'h7fff_ffff_ffff;
  localparam logic [DW-1:0] LIM_NEG = 48'h8000_0000_0000;

  typedef struct packed {
    logic start;
    logic div;
  } mdu_req_t;

  typedef enum logic [1:0] {
    MDU_IDLE,
    MDU_MUL,
    MDU_DIV,
    MDU_FIN
  } mdu_st_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WARM,
    ST_PRE_EE,
    ST_PRE_RATIO,
    ST_PRE_SQ,
    ST_PRE_AH,
    ST_K_INIT,
    ST_K_MA,
    ST_K_ARCH,
    ST_K_GARCH,
    ST_T1M,
    ST_T1D,
    ST_T2M,
    ST_T2D,
    ST_WRAP,
    ST_EMIT
  } st_t;

  function automatic logic signed [DW-1:0] sat48(input logic signed [DW:0] x);
    if (x > MAX48_W) return MAX48_W[DW-1:0];
    else if (x < MIN48_W) return MIN48_W[DW-1:0];
    else return x[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    return sat48(s);
  endfunction

  function automatic logic signed [DW-1:0] sat_sub(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    return sat48(s);
  endfunction

  function automatic logic signed [DW-1:0] sat_dbl(input logic signed [DW-1:0] a);
    logic signed [DW:0] s;
    s = {a, 1'b0};
    return sat48(s);
  endfunction

  function automatic logic [DW-1:0] mag48(input logic signed [DW-1:0] x);
    return x[DW-1] ? 48'(-x) : 48'(x);
  endfunction

endpackage

[hw/rtl/agl_mdu.sv]
// shared multiply / divide unit: q24.24 multiply by partial products, restoring divide
module agl_mdu (
  input  logic                   clk,
  input  logic                   rst_n,
  input  agl_pkg::mdu_req_t      req,
  input  logic signed [47:0]     opa,
  input  logic signed [47:0]     opb,
  input  logic [47:0]            den,
  output logic                   done,
  output logic signed [47:0]     res
);

  agl_pkg::mdu_st_t st_r, st_nxt;
  logic             done_r, done_nxt;
  logic signed [47:0] res_r, res_nxt;
  logic             div_r, div_nxt;
  logic             neg_r, neg_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic [47:0]      ua_r, ua_nxt;
  logic [47:0]      ub_r, ub_nxt;
  logic [95:0]      acc_r, acc_nxt;
  logic [71:0]      dvd_r, dvd_nxt;
  logic [47:0]      rem_r, rem_nxt;
  logic [47:0]      q_r, q_nxt;
  logic             ovf_r, ovf_nxt;
  logic [47:0]      den_r, den_nxt;

  logic [23:0] pa, pb;
  logic [47:0] pp;
  logic [95:0] pps;
  logic [1:0]  shs;
  logic [48:0] rsh;
  logic        ge;
  logic [47:0] mg, lim;
  logic        ov;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= agl_pkg::MDU_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    res_r <= res_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    ua_r  <= ua_nxt;
    ub_r  <= ub_nxt;
    acc_r <= acc_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    den_r <= den_nxt;
  end

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    ua_nxt   = ua_r;
    ub_nxt   = ub_r;
    acc_nxt  = acc_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    den_nxt  = den_r;
    pa  = cnt_r[1] ? ua_r[47:24] : ua_r[23:0];
    pb  = cnt_r[0] ? ub_r[47:24] : ub_r[23:0];
    pp  = 48'(pa * pb);
    shs = 2'(cnt_r[1]) + 2'(cnt_r[0]);
    unique case (shs)
      2'd0:    pps = {48'b0, pp};
      2'd1:    pps = {24'b0, pp, 24'b0};
      default: pps = {pp, 48'b0};
    endcase
    rsh = {rem_r, dvd_r[71]};
    ge  = rsh >= {1'b0, den_r};
    mg  = div_r ? q_r : acc_r[71:24];
    ov  = div_r ? ovf_r : (|acc_r[95:72]);
    lim = neg_r ? agl_pkg::LIM_NEG : agl_pkg::LIM_POS;
    if (ov || mg > lim) mg = lim;
    unique case (st_r)
      agl_pkg::MDU_IDLE: begin
        if (req.start) begin
          div_nxt = req.div;
          neg_nxt = req.div ? opa[47] : (opa[47] ^ opb[47]);
          ua_nxt  = agl_pkg::mag48(opa);
          ub_nxt  = agl_pkg::mag48(opb);
          acc_nxt = '0;
          dvd_nxt = {agl_pkg::mag48(opa), 24'b0};
          rem_nxt = '0;
          q_nxt   = '0;
          ovf_nxt = 1'b0;
          den_nxt = den;
          cnt_nxt = req.div ? 7'd71 : 7'd0;
          st_nxt  = req.div ? agl_pkg::MDU_DIV : agl_pkg::MDU_MUL;
        end
      end
      agl_pkg::MDU_MUL: begin
        acc_nxt = acc_r + pps;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd3) st_nxt = agl_pkg::MDU_FIN;
      end
      agl_pkg::MDU_DIV: begin
        rem_nxt = ge ? 48'(rsh - {1'b0, den_r}) : rsh[47:0];
        q_nxt   = {q_r[46:0], ge};
        if (ge && cnt_r >= 7'd48) ovf_nxt = 1'b1;
        dvd_nxt = {dvd_r[70:0], 1'b0};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd0) st_nxt = agl_pkg::MDU_FIN;
      end
      agl_pkg::MDU_FIN: begin
        res_nxt  = neg_r ? 48'(-mg) : mg;
        done_nxt = 1'b1;
        st_nxt   = agl_pkg::MDU_IDLE;
      end
      default: st_nxt = agl_pkg::MDU_IDLE;
    endcase
  end

  assign done = done_r;
  assign res  = res_r;

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(st_r == agl_pkg::MDU_FIN))
    else $error("result without finishing step");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> st_r == agl_pkg::MDU_IDLE)
    else $error("operation issued while busy");
  a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == agl_pkg::MDU_MUL |-> cnt_r <= 7'd3)
    else $error("multiply step count out of range");

endmodule

[hw/rtl/arma_garch_loglik_gradient_core.sv]
// top level: arma-garch gaussian log-likelihood gradient core with step sequencer
// One series step per input transfer; the block stalls its input while a step is worked.
// All products and quotients go through one shared multiply/divide unit, which holds the
// sequencer while it works. A full step updates P gradients, with P = 2 + AR + MA + ARCH + GARCH.
// The final step then sends P gradient transfers, one per cycle when the output is not stalled,
// and clears the series state. No clearing pass.
module arma_garch_loglik_gradient_core #(
  parameter int AR_ORDER    = 1,
  parameter int MA_ORDER    = 1,
  parameter int GARCH_ORDER = 1,
  parameter int ARCH_ORDER  = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [47:0]  in_sample_value,
  input  logic signed [47:0]  in_residual,
  input  logic [46:0]         in_variance,
  input  logic                in_end_of_series,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_grad_index,
  output logic signed [47:0]  out_grad_value,
  output logic                out_grad_last,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  localparam int NAR = AR_ORDER < 0 ? 0 : AR_ORDER > 2 ? 2 : AR_ORDER;
  localparam int NMA = MA_ORDER < 0 ? 0 : MA_ORDER > 2 ? 2 : MA_ORDER;
  localparam int NARCH = ARCH_ORDER < 0 ? 0 : ARCH_ORDER > 2 ? 2 : ARCH_ORDER;
  localparam int NGARCH = GARCH_ORDER < 0 ? 0 : GARCH_ORDER > 2 ? 2 : GARCH_ORDER;
  localparam int NPAR = 2 + NAR + NMA + NARCH + NGARCH;
  localparam int KW = $clog2(NPAR);
  localparam int AR_BASE = 2;
  localparam int MA_BASE = AR_BASE + NAR;
  localparam int ARCH_BASE = MA_BASE + NMA;
  localparam int GARCH_BASE = ARCH_BASE + NARCH;

  agl_pkg::st_t st_r, st_nxt;
  logic pend_r, pend_nxt;

  logic signed [47:0] ma1_r, ma1_nxt, ma2_r, ma2_nxt;
  logic signed [47:0] ar1_r, ar1_nxt, ar2_r, ar2_nxt;
  logic signed [47:0] ga1_r, ga1_nxt, ga2_r, ga2_nxt;
  logic [15:0]        wu_r, wu_nxt;

  logic signed [47:0] s_r, s_nxt, e_r, e_nxt;
  logic [46:0]        v_r, v_nxt;
  logic               last_r, last_nxt;

  logic signed [47:0] sh0_r, sh0_nxt, sh1_r, sh1_nxt;
  logic signed [47:0] rh0_r, rh0_nxt, rh1_r, rh1_nxt;
  logic [46:0]        vh0_r, vh0_nxt, vh1_r, vh1_nxt;
  logic [15:0]        cnt_r, cnt_nxt;

  logic signed [47:0] rs0_r [NPAR], rs0_nxt [NPAR];
  logic signed [47:0] rs1_r [NPAR], rs1_nxt [NPAR];
  logic signed [47:0] vs0_r [NPAR], vs0_nxt [NPAR];
  logic signed [47:0] vs1_r [NPAR], vs1_nxt [NPAR];
  logic signed [47:0] g_r [NPAR], g_nxt [NPAR];

  logic signed [47:0] sq_r [2], sq_nxt [2];
  logic signed [47:0] ah_r [2], ah_nxt [2];
  logic signed [47:0] fac_r, fac_nxt, t_r, t_nxt, t13_r, t13_nxt;
  logic signed [47:0] de_r, de_nxt, ds_r, ds_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic               j_r, j_nxt;

  agl_pkg::mdu_req_t  req;
  logic signed [47:0] mdu_a, mdu_b, mdu_res;
  logic [47:0]        mdu_den;
  logic               mdu_done;
  logic               op;

  agl_mdu u_mdu (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .opa  (mdu_a),
    .opb  (mdu_b),
    .den  (mdu_den),
    .done (mdu_done),
    .res  (mdu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= agl_pkg::ST_IDLE;
      pend_r <= 1'b0;
      ma1_r  <= '0;
      ma2_r  <= '0;
      ar1_r  <= '0;
      ar2_r  <= '0;
      ga1_r  <= '0;
      ga2_r  <= '0;
      wu_r   <= agl_pkg::WARMUP_RST;
      sh0_r  <= '0;
      sh1_r  <= '0;
      rh0_r  <= '0;
      rh1_r  <= '0;
      vh0_r  <= '0;
      vh1_r  <= '0;
      cnt_r  <= '0;
      for (int i = 0; i < NPAR; i++) begin
        rs0_r[i] <= '0;
        rs1_r[i] <= '0;
        vs0_r[i] <= '0;
        vs1_r[i] <= '0;
        g_r[i]   <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
      ma1_r  <= ma1_nxt;
      ma2_r  <= ma2_nxt;
      ar1_r  <= ar1_nxt;
      ar2_r  <= ar2_nxt;
      ga1_r  <= ga1_nxt;
      ga2_r  <= ga2_nxt;
      wu_r   <= wu_nxt;
      sh0_r  <= sh0_nxt;
      sh1_r  <= sh1_nxt;
      rh0_r  <= rh0_nxt;
      rh1_r  <= rh1_nxt;
      vh0_r  <= vh0_nxt;
      vh1_r  <= vh1_nxt;
      cnt_r  <= cnt_nxt;
      rs0_r  <= rs0_nxt;
      rs1_r  <= rs1_nxt;
      vs0_r  <= vs0_nxt;
      vs1_r  <= vs1_nxt;
      g_r    <= g_nxt;
    end
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    v_r    <= v_nxt;
    last_r <= last_nxt;
    sq_r   <= sq_nxt;
    ah_r   <= ah_nxt;
    fac_r  <= fac_nxt;
    t_r    <= t_nxt;
    t13_r  <= t13_nxt;
    de_r   <= de_nxt;
    ds_r   <= ds_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
  end

  always_comb begin
    int kk;
    logic jk;
    logic signed [47:0] rhj;
    logic signed [47:0] rsk, vsk;
    logic klast;
    st_nxt  = st_r;
    pend_nxt = pend_r;
    ma1_nxt = ma1_r;
    ma2_nxt = ma2_r;
    ar1_nxt = ar1_r;
    ar2_nxt = ar2_r;
    ga1_nxt = ga1_r;
    ga2_nxt = ga2_r;
    wu_nxt  = wu_r;
    s_nxt   = s_r;
    e_nxt   = e_r;
    v_nxt   = v_r;
    last_nxt = last_r;
    sh0_nxt = sh0_r;
    sh1_nxt = sh1_r;
    rh0_nxt = rh0_r;
    rh1_nxt = rh1_r;
    vh0_nxt = vh0_r;
    vh1_nxt = vh1_r;
    cnt_nxt = cnt_r;
    rs0_nxt = rs0_r;
    rs1_nxt = rs1_r;
    vs0_nxt = vs0_r;
    vs1_nxt = vs1_r;
    g_nxt   = g_r;
    sq_nxt  = sq_r;
    ah_nxt  = ah_r;
    fac_nxt = fac_r;
    t_nxt   = t_r;
    t13_nxt = t13_r;
    de_nxt  = de_r;
    ds_nxt  = ds_r;
    k_nxt   = k_r;
    j_nxt   = j_r;
    mdu_a   = '0;
    mdu_b   = '0;
    mdu_den = '0;
    req.div = 1'b0;
    op      = 1'b0;
    kk      = int'(k_r);
    jk      = 1'b0;
    rhj     = j_r ? rh1_r : rh0_r;
    rsk     = j_r ? rs1_r[k_r] : rs0_r[k_r];
    vsk     = j_r ? vs1_r[k_r] : vs0_r[k_r];
    klast   = k_r == KW'(NPAR - 1);

    if (cfg_we) begin
      unique case (cfg_index)
        agl_pkg::CFG_MA1:    ma1_nxt = cfg_data;
        agl_pkg::CFG_MA2:    ma2_nxt = cfg_data;
        agl_pkg::CFG_ARCH1:  ar1_nxt = cfg_data;
        agl_pkg::CFG_ARCH2:  ar2_nxt = cfg_data;
        agl_pkg::CFG_GARCH1: ga1_nxt = cfg_data;
        agl_pkg::CFG_GARCH2: ga2_nxt = cfg_data;
        agl_pkg::CFG_WARMUP: wu_nxt = cfg_data[15:0];
        default: ;
      endcase
    end

    unique case (st_r)
      agl_pkg::ST_IDLE: begin
        if (in_valid) begin
          s_nxt    = in_sample_value;
          e_nxt    = in_residual;
          v_nxt    = (in_variance == '0) ? 47'd1 : in_variance;
          last_nxt = in_end_of_series;
          st_nxt   = (cnt_r < wu_r) ? agl_pkg::ST_WARM : agl_pkg::ST_PRE_EE;
        end
      end
      agl_pkg::ST_WARM: begin
        for (int i = 0; i < NPAR; i++) begin
          rs1_nxt[i] = rs0_r[i];
          rs0_nxt[i] = '0;
          vs1_nxt[i] = vs0_r[i];
          vs0_nxt[i] = '0;
        end
        st_nxt = agl_pkg::ST_WRAP;
      end
      agl_pkg::ST_PRE_EE: begin
        op = 1'b1;
        mdu_a = e_r;
        mdu_b = e_r;
        if (mdu_done) begin
          t_nxt  = mdu_res;
          st_nxt = agl_pkg::ST_PRE_RATIO;
        end
      end
      agl_pkg::ST_PRE_RATIO: begin
        op = 1'b1;
        req.div = 1'b1;
        mdu_a = t_r;
        mdu_den = {1'b0, v_r};
        if (mdu_done) begin
          fac_nxt = agl_pkg::sat_sub(mdu_res, agl_pkg::ONE_Q);
          j_nxt = 1'b0;
          k_nxt = '0;
          st_nxt = (NARCH > 0) ? agl_pkg::ST_PRE_SQ : agl_pkg::ST_K_INIT;
        end
      end
      agl_pkg::ST_PRE_SQ: begin
        op = 1'b1;
        mdu_a = rhj;
        mdu_b = rhj;
        if (mdu_done) begin
          sq_nxt[j_r] = mdu_res;
          if (j_r == 1'(NARCH - 1)) begin
            j_nxt = 1'b0;
            st_nxt = agl_pkg::ST_PRE_AH;
          end else begin
            j_nxt = 1'b1;
          end
        end
      end
      agl_pkg::ST_PRE_AH: begin
        op = 1'b1;
        mdu_a = j_r ? ar2_r : ar1_r;
        mdu_b = rhj;
        if (mdu_done) begin
          ah_nxt[j_r] = mdu_res;
          if (j_r == 1'(NARCH - 1)) begin
            j_nxt = 1'b0;
            st_nxt = agl_pkg::ST_K_INIT;
          end else begin
            j_nxt = 1'b1;
          end
        end
      end
      agl_pkg::ST_K_INIT: begin
        if (kk == 0) begin
          de_nxt = agl_pkg::MINUS_ONE_Q;
        end else if (kk >= AR_BASE && kk < MA_BASE) begin
          jk = 1'(kk - AR_BASE);
          de_nxt = agl_pkg::sat_sub('0, jk ? sh1_r : sh0_r);
        end else if (kk >= MA_BASE && kk < ARCH_BASE) begin
          jk = 1'(kk - MA_BASE);
          de_nxt = agl_pkg::sat_sub('0, jk ? rh1_r : rh0_r);
        end else begin
          de_nxt = '0;
        end
        if (kk == 1) begin
          ds_nxt = agl_pkg::ONE_Q;
        end else if (kk >= ARCH_BASE && kk < GARCH_BASE) begin
          ds_nxt = sq_r[1'(kk - ARCH_BASE)];
        end else if (kk >= GARCH_BASE) begin
          ds_nxt = (1'(kk - GARCH_BASE)) ? {1'b0, vh1_r} : {1'b0, vh0_r};
        end else begin
          ds_nxt = '0;
        end
        j_nxt = 1'b0;
        if (NMA > 0) st_nxt = agl_pkg::ST_K_MA;
        else if (NARCH > 0) st_nxt = agl_pkg::ST_K_ARCH;
        else if (NGARCH > 0) st_nxt = agl_pkg::ST_K_GARCH;
        else st_nxt = agl_pkg::ST_T1M;
      end
      agl_pkg::ST_K_MA: begin
        op = 1'b1;
        mdu_a = j_r ? ma2_r : ma1_r;
        mdu_b = rsk;
        if (mdu_done) begin
          de_nxt = agl_pkg::sat_sub(de_r, mdu_res);
          if (j_r == 1'(NMA - 1)) begin
            j_nxt = 1'b0;
            if (NARCH > 0) st_nxt = agl_pkg::ST_K_ARCH;
            else if (NGARCH > 0) st_nxt = agl_pkg::ST_K_GARCH;
            else st_nxt = agl_pkg::ST_T1M;
          end else begin
            j_nxt = 1'b1;
          end
        end
      end
      agl_pkg::ST_K_ARCH: begin
        op = 1'b1;
        mdu_a = ah_r[j_r];
        mdu_b = rsk;
        if (mdu_done) begin
          ds_nxt = agl_pkg::sat_add(ds_r, agl_pkg::sat_dbl(mdu_res));
          if (j_r == 1'(NARCH - 1)) begin
            j_nxt = 1'b0;
            st_nxt = (NGARCH > 0) ? agl_pkg::ST_K_GARCH : agl_pkg::ST_T1M;
          end else begin
            j_nxt = 1'b1;
          end
        end
      end
      agl_pkg::ST_K_GARCH: begin
        op = 1'b1;
        mdu_a = j_r ? ga2_r : ga1_r;
        mdu_b = vsk;
        if (mdu_done) begin
          ds_nxt = agl_pkg::sat_add(ds_r, mdu_res);
          if (j_r == 1'(NGARCH - 1)) begin
            j_nxt = 1'b0;
            st_nxt = agl_pkg::ST_T1M;
          end else begin
            j_nxt = 1'b1;
          end
        end
      end
      agl_pkg::ST_T1M: begin
        op = 1'b1;
        mdu_a = ds_r;
        mdu_b = fac_r;
        if (mdu_done) begin
          t_nxt = mdu_res;
          st_nxt = agl_pkg::ST_T1D;
        end
      end
      agl_pkg::ST_T1D: begin
        op = 1'b1;
        req.div = 1'b1;
        mdu_a = t_r;
        mdu_den = {v_r, 1'b0};
        if (mdu_done) begin
          t13_nxt = mdu_res;
          st_nxt = agl_pkg::ST_T2M;
        end
      end
      agl_pkg::ST_T2M: begin
        op = 1'b1;
        mdu_a = e_r;
        mdu_b = de_r;
        if (mdu_done) begin
          t_nxt = mdu_res;
          st_nxt = agl_pkg::ST_T2D;
        end
      end
      agl_pkg::ST_T2D: begin
        op = 1'b1;
        req.div = 1'b1;
        mdu_a = t_r;
        mdu_den = {1'b0, v_r};
        if (mdu_done) begin
          g_nxt[k_r] = agl_pkg::sat_sub(agl_pkg::sat_add(g_r[k_r], t13_r), mdu_res);
          rs1_nxt[k_r] = rs0_r[k_r];
          rs0_nxt[k_r] = de_r;
          vs1_nxt[k_r] = vs0_r[k_r];
          vs0_nxt[k_r] = ds_r;
          if (klast) begin
            st_nxt = agl_pkg::ST_WRAP;
          end else begin
            k_nxt = k_r + KW'(1);
            st_nxt = agl_pkg::ST_K_INIT;
          end
        end
      end
      agl_pkg::ST_WRAP: begin
        sh1_nxt = sh0_r;
        sh0_nxt = s_r;
        rh1_nxt = rh0_r;
        rh0_nxt = e_r;
        vh1_nxt = vh0_r;
        vh0_nxt = v_r;
        if (cnt_r != agl_pkg::CNT_MAX) cnt_nxt = cnt_r + 16'd1;
        k_nxt = '0;
        st_nxt = last_r ? agl_pkg::ST_EMIT : agl_pkg::ST_IDLE;
      end
      agl_pkg::ST_EMIT: begin
        if (!out_stall) begin
          if (klast) begin
            sh0_nxt = '0;
            sh1_nxt = '0;
            rh0_nxt = '0;
            rh1_nxt = '0;
            vh0_nxt = '0;
            vh1_nxt = '0;
            cnt_nxt = '0;
            for (int i = 0; i < NPAR; i++) begin
              rs0_nxt[i] = '0;
              rs1_nxt[i] = '0;
              vs0_nxt[i] = '0;
              vs1_nxt[i] = '0;
              g_nxt[i]   = '0;
            end
            st_nxt = agl_pkg::ST_IDLE;
          end else begin
            k_nxt = k_r + KW'(1);
          end
        end
      end
      default: st_nxt = agl_pkg::ST_IDLE;
    endcase

    req.start = op && !pend_r;
    if (req.start) pend_nxt = 1'b1;
    else if (mdu_done) pend_nxt = 1'b0;
  end

  assign in_stall       = st_r != agl_pkg::ST_IDLE;
  assign out_valid      = st_r == agl_pkg::ST_EMIT;
  assign out_grad_index = 4'(k_r);
  assign out_grad_value = g_r[k_r];
  assign out_grad_last  = k_r == KW'(NPAR - 1);

endmodule
